FILE: rtl/ple_pkg.sv
// Package for the positional list engine: widths, operation and status
// codes, and the command that the controller broadcasts to the cell row.
// Depends on nothing; every other file uses it by scoped names.
package ple_pkg;

  // Number of elements the list can hold.
  localparam int DEPTH = 16;

  // Fixed field widths of the beats.
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  // Widths derived from the depth.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_READ      = 3'd6;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // What each cell does in a cycle.
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INS,
    ACT_DEL
  } act_t;

  // Command broadcast to every cell.
  typedef struct packed {
    act_t                     act;
    logic [CMP_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: rtl/ple_if.sv
// Channel interfaces of the positional list engine: the operation channel
// and the result channel, each with valid/ready and its payload.
// Depends on ple_pkg for the field widths.
interface ple_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [ple_pkg::OP_W-1:0]                 operation;
  logic signed [ple_pkg::DATA_W-1:0]        data_value;
  logic [ple_pkg::POS_W-1:0]                position;

  modport source (output valid, output operation, output data_value, output position,
                  input ready);
  modport sink   (input valid, input operation, input data_value, input position,
                  output ready);
endinterface

interface ple_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [ple_pkg::ST_W-1:0]                 status;
  logic [ple_pkg::CNT_OUT_W-1:0]            element_count;
  logic signed [ple_pkg::DATA_W-1:0]        read_value;

  modport source (output valid, output status, output element_count, output read_value,
                  input ready);
  modport sink   (input valid, input status, input element_count, input read_value,
                  output ready);
endinterface

FILE: rtl/ple_cell.sv
// One storage cell of the list row: holds the element at its position and
// takes its own value, its left or right neighbor's value or the inserted
// value each cycle. Depends on ple_pkg for the command struct and widths.
module ple_cell (
  input  logic                              clk,
  input  ple_pkg::cell_cmd_t                cmd,
  input  logic [ple_pkg::CMP_W-1:0]         my_idx,
  input  logic signed [ple_pkg::DATA_W-1:0] left_val,
  input  logic signed [ple_pkg::DATA_W-1:0] right_val,
  output logic signed [ple_pkg::DATA_W-1:0] val_q
);

  logic signed [ple_pkg::DATA_W-1:0] val_r;
  logic signed [ple_pkg::DATA_W-1:0] val_nxt;

  // An insert opens a gap at the position; a delete closes it.
  always_comb begin
    val_nxt = val_r;
    case (cmd.act)
      ple_pkg::ACT_INS: begin
        if (my_idx == cmd.pos) begin
          val_nxt = cmd.value;
        end else if (my_idx > cmd.pos) begin
          val_nxt = left_val;
        end
      end
      ple_pkg::ACT_DEL: begin
        if (my_idx >= cmd.pos) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule

FILE: rtl/ple_ctrl.sv
// Controller of the list engine: decodes each operation beat, checks it
// against the count, drives the cell row and registers the result beat.
// Depends on ple_pkg and the channel interfaces in ple_if.
module ple_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  ple_in_if.sink                            in_ch,
  ple_out_if.source                         out_ch,
  input  logic signed [ple_pkg::DATA_W-1:0] cell_val [ple_pkg::DEPTH],
  output ple_pkg::cell_cmd_t                cmd,
  output logic [ple_pkg::CNT_W-1:0]         cnt_q
);

  localparam logic [ple_pkg::CMP_W-1:0] DEPTH_C = ple_pkg::CMP_W'(ple_pkg::DEPTH);
  localparam logic [ple_pkg::CMP_W-1:0] ONE_C   = ple_pkg::CMP_W'(1);

  logic [ple_pkg::CNT_W-1:0]         cnt_r;
  logic [ple_pkg::CNT_W-1:0]         cnt_nxt;
  logic                              out_valid_r;
  logic [ple_pkg::ST_W-1:0]          status_r;
  logic [ple_pkg::ST_W-1:0]          status_nxt;
  logic [ple_pkg::CNT_OUT_W-1:0]     count_r;
  logic signed [ple_pkg::DATA_W-1:0] rd_r;
  logic signed [ple_pkg::DATA_W-1:0] rd_nxt;

  logic                              accept;
  logic [ple_pkg::CMP_W-1:0]         cnt_w;
  logic [ple_pkg::CMP_W-1:0]         pos_w;
  logic [ple_pkg::CMP_W-1:0]         cnt_after;
  logic [ple_pkg::IDX_W-1:0]         rd_idx;
  logic                              full;
  logic                              empty;
  ple_pkg::act_t                     act;
  logic [ple_pkg::CMP_W-1:0]         op_pos;

  // A new beat enters when the result register is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cnt_w  = ple_pkg::CMP_W'(cnt_r);
  assign pos_w  = ple_pkg::CMP_W'(in_ch.position);
  assign rd_idx = pos_w[ple_pkg::IDX_W-1:0];
  assign full   = (cnt_w == DEPTH_C);
  assign empty  = (cnt_w == '0);

  // Decode the operation and check it against the current count.
  always_comb begin
    act        = ple_pkg::ACT_HOLD;
    op_pos     = '0;
    status_nxt = ple_pkg::ST_OK;
    rd_nxt     = '0;
    case (in_ch.operation)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT: begin
        if (in_ch.operation == ple_pkg::OP_INS_BACK) begin
          op_pos = cnt_w;
        end else if (in_ch.operation == ple_pkg::OP_INS_AT) begin
          op_pos = pos_w;
        end
        if (full) begin
          status_nxt = ple_pkg::ST_FULL;
        end else if (op_pos > cnt_w) begin
          status_nxt = ple_pkg::ST_RANGE;
        end else begin
          act = ple_pkg::ACT_INS;
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_AT: begin
        if (in_ch.operation == ple_pkg::OP_DEL_BACK) begin
          op_pos = cnt_w - ONE_C;
        end else if (in_ch.operation == ple_pkg::OP_DEL_AT) begin
          op_pos = pos_w;
        end
        if (empty) begin
          status_nxt = ple_pkg::ST_EMPTY;
        end else if (op_pos >= cnt_w) begin
          status_nxt = ple_pkg::ST_RANGE;
        end else begin
          act = ple_pkg::ACT_DEL;
        end
      end
      ple_pkg::OP_READ: begin
        if (empty) begin
          status_nxt = ple_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_nxt = ple_pkg::ST_RANGE;
        end else begin
          rd_nxt = cell_val[rd_idx];
        end
      end
      default: status_nxt = ple_pkg::ST_OK;
    endcase
  end

  // The cells move only on an accepted beat.
  assign cmd.act   = accept ? act : ple_pkg::ACT_HOLD;
  assign cmd.pos   = op_pos;
  assign cmd.value = in_ch.data_value;

  // Count after the operation.
  always_comb begin
    cnt_after = cnt_w;
    case (act)
      ple_pkg::ACT_INS: cnt_after = cnt_w + ONE_C;
      ple_pkg::ACT_DEL: cnt_after = cnt_w - ONE_C;
      default:          cnt_after = cnt_w;
    endcase
    cnt_nxt = accept ? cnt_after[ple_pkg::CNT_W-1:0] : cnt_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      count_r  <= cnt_after[ple_pkg::CNT_OUT_W-1:0];
      rd_r     <= rd_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.element_count = count_r;
  assign out_ch.read_value    = rd_r;
  assign cnt_q                = cnt_r;

endmodule

FILE: rtl/positional_list_engine.sv
// Top level of the positional list engine: the controller and a row of
// DEPTH storage cells. Depends on ple_pkg, ple_if, ple_cell and ple_ctrl.
//
// Usage:
//   in_ch carries one operation beat (operation, data_value, position):
//   insert at front, back or a position; delete at front, back or a
//   position; or read the element at a position. out_ch returns one beat
//   per operation: status, element count after the operation, read value.
//   A beat accepted at one edge shows its result beat from the next cycle
//   on. Throughput is one operation per cycle while out_ch takes results,
//   since every cell moves its element to a neighbor in the same cycle
//   that the controller checks the operation. A stalled result beat holds
//   in the output register, and in_ch.ready drops until it is taken.
//   Errors (bad position, empty list, full list) leave the list unchanged.
//   Synchronous reset empties the list and drops the result valid; element
//   contents are not cleared, as no entry is read before it is written.
module positional_list_engine (
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  ple_pkg::cell_cmd_t                cmd;
  logic [ple_pkg::CNT_W-1:0]         cnt;
  logic signed [ple_pkg::DATA_W-1:0] cell_val [ple_pkg::DEPTH];

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cell_val (cell_val),
    .cmd      (cmd),
    .cnt_q    (cnt)
  );

  // Row of cells; the ends see zero from outside the row.
  for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left_v;
    logic signed [ple_pkg::DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == ple_pkg::DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    ple_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .my_idx    (ple_pkg::CMP_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .val_q     (cell_val[i])
    );
  end

  // The count never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ple_pkg::CMP_W'(cnt) <= ple_pkg::CMP_W'(ple_pkg::DEPTH))
    else $error("element count above depth");

  // The count only moves on an accepted beat.
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.valid && in_ch.ready) |=> $stable(cnt))
    else $error("count changed without an accepted beat");

  // An accepted beat gives a result beat in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> out_ch.valid)
    else $error("accepted beat produced no result");

  // A full status means the list really is full.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ple_pkg::ST_FULL) |->
      ple_pkg::CMP_W'(cnt) == ple_pkg::CMP_W'(ple_pkg::DEPTH))
    else $error("full status with room left");

endmodule

FILE: dv/tb.sv
// Testbench for the positional list engine: drives operation beats, predicts
// each result beat and checks it. Depends on ple_pkg, ple_if and the RTL top.
`timescale 1ns / 1ps

module tb;

  // Operation code seven has no function; the block must leave the list alone.
  localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 5;

  // One expected result beat.
  typedef struct packed {
    logic [ple_pkg::ST_W-1:0]          status;
    logic [ple_pkg::CNT_OUT_W-1:0]     count;
    logic signed [ple_pkg::DATA_W-1:0] value;
  } list_result_t;

  // Scoreboard: a shadow copy of the list plus the queue of results still due.
  class list_scoreboard;
    logic signed [ple_pkg::DATA_W-1:0] cells[ple_pkg::DEPTH];
    int unsigned held;
    list_result_t due_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned noted;
    int unsigned by_status[4];

    function logic [ple_pkg::ST_W-1:0] insert_at(int unsigned at,
                                                 logic signed [ple_pkg::DATA_W-1:0] v);
      if (held >= ple_pkg::DEPTH) return ple_pkg::ST_FULL;
      if (at > held) return ple_pkg::ST_RANGE;
      for (int unsigned i = held; i > at; i--) cells[i] = cells[i-1];
      cells[at] = v;
      held++;
      return ple_pkg::ST_OK;
    endfunction

    function logic [ple_pkg::ST_W-1:0] remove_at(int unsigned at);
      if (held == 0) return ple_pkg::ST_EMPTY;
      if (at >= held) return ple_pkg::ST_RANGE;
      for (int unsigned i = at; i + 1 < held; i++) cells[i] = cells[i+1];
      held--;
      return ple_pkg::ST_OK;
    endfunction

    // Apply one accepted operation beat to the shadow list and queue its result.
    function void note_op(logic [ple_pkg::OP_W-1:0] op,
                          logic signed [ple_pkg::DATA_W-1:0] v,
                          logic [ple_pkg::POS_W-1:0] at);
      list_result_t r;
      r = '0;
      case (op)
        ple_pkg::OP_INS_FRONT: r.status = insert_at(0, v);
        ple_pkg::OP_INS_BACK:  r.status = insert_at(held, v);
        ple_pkg::OP_INS_AT:    r.status = insert_at(at, v);
        ple_pkg::OP_DEL_FRONT: r.status = remove_at(0);
        ple_pkg::OP_DEL_BACK:
          r.status = (held == 0) ? ple_pkg::ST_EMPTY : remove_at(held - 1);
        ple_pkg::OP_DEL_AT:    r.status = remove_at(at);
        ple_pkg::OP_READ: begin
          if (held == 0) r.status = ple_pkg::ST_EMPTY;
          else if (at >= held) r.status = ple_pkg::ST_RANGE;
          else r.value = cells[at];
        end
        default: ;
      endcase
      r.count = held[ple_pkg::CNT_OUT_W-1:0];
      by_status[r.status]++;
      noted++;
      due_q.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(logic [ple_pkg::ST_W-1:0] st,
                               logic [ple_pkg::CNT_OUT_W-1:0] cnt,
                               logic signed [ple_pkg::DATA_W-1:0] v);
      list_result_t exp;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result beat status=%0d count=%0d value=%0d",
                         st, cnt, v));
        return;
      end
      exp = due_q.pop_front();
      checked++;
      if (st !== exp.status || cnt !== exp.count || v !== exp.value)
        report($sformatf("result %0d: expected status=%0d count=%0d value=%0d, got %0d/%0d/%0d",
                         checked, exp.status, exp.count, exp.value, st, cnt, v));
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  positional_list_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor and watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.status, out_ch.element_count, out_ch.read_value);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one operation beat, with random idle cycles ahead of it.
  task automatic send_op(logic [ple_pkg::OP_W-1:0] op,
                         logic signed [ple_pkg::DATA_W-1:0] v,
                         logic [ple_pkg::POS_W-1:0] at);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.data_value <= v;
    in_ch.position   <= at;
    do @(posedge clk); while (!in_ch.ready);
    board.note_op(op, v, at);
  endtask

  function automatic logic signed [ple_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  // Random operations that alternately fill the list to full and drain it to
  // empty, so the full and empty corners come up again and again.
  task automatic run_random(int n);
    int done;
    int r;
    bit filling;
    logic [ple_pkg::OP_W-1:0] op;
    logic [ple_pkg::POS_W-1:0] at;
    done = 0;
    filling = 1'b1;
    while (done < n) begin
      if (board.held == ple_pkg::DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      if (board.held == 0 && $urandom_range(3) == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (r < 3) op = OP_UNUSED;
      else if (filling) begin
        if (r < 28) op = ple_pkg::OP_INS_FRONT;
        else if (r < 53) op = ple_pkg::OP_INS_BACK;
        else if (r < 73) op = ple_pkg::OP_INS_AT;
        else if (r < 85) op = ple_pkg::OP_READ;
        else if (r < 90) op = ple_pkg::OP_DEL_FRONT;
        else if (r < 95) op = ple_pkg::OP_DEL_BACK;
        else op = ple_pkg::OP_DEL_AT;
      end else begin
        if (r < 28) op = ple_pkg::OP_DEL_FRONT;
        else if (r < 53) op = ple_pkg::OP_DEL_BACK;
        else if (r < 73) op = ple_pkg::OP_DEL_AT;
        else if (r < 85) op = ple_pkg::OP_READ;
        else if (r < 90) op = ple_pkg::OP_INS_FRONT;
        else if (r < 95) op = ple_pkg::OP_INS_BACK;
        else op = ple_pkg::OP_INS_AT;
      end
      // Mostly positions near the live range, now and then any 5-bit value.
      if ($urandom_range(4) == 0) at = ple_pkg::POS_W'($urandom_range(31));
      else at = ple_pkg::POS_W'($urandom_range(board.held));
      send_op(op, pick_value(), at);
      if (op != OP_UNUSED) done++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = ple_pkg::OP_INS_FRONT;
    in_ch.data_value = '0;
    in_ch.position = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-list errors, range checks, extremes, every operation.
    send_idle_pct = 22;
    recv_idle_pct = 59;
    send_op(ple_pkg::OP_READ, '0, 5'd0);
    send_op(ple_pkg::OP_DEL_FRONT, '0, 5'd0);
    send_op(ple_pkg::OP_DEL_BACK, '0, 5'd0);
    send_op(ple_pkg::OP_DEL_AT, '0, 5'd31);
    send_op(ple_pkg::OP_INS_AT, 32'sd5, 5'd1);
    send_op(ple_pkg::OP_INS_FRONT, 32'sh7fffffff, 5'd31);
    send_op(ple_pkg::OP_INS_BACK, 32'sh80000000, 5'd0);
    send_op(ple_pkg::OP_INS_AT, -32'sd1, 5'd1);
    send_op(ple_pkg::OP_INS_AT, 32'sh5a5a5a5a, 5'd3);
    send_op(ple_pkg::OP_INS_AT, 32'sd7, 5'd5);
    send_op(ple_pkg::OP_READ, '0, 5'd0);
    send_op(ple_pkg::OP_READ, '0, 5'd1);
    send_op(ple_pkg::OP_READ, '0, 5'd2);
    send_op(ple_pkg::OP_READ, '0, 5'd3);
    send_op(ple_pkg::OP_READ, '0, 5'd4);
    send_op(ple_pkg::OP_READ, '0, 5'd31);
    send_op(OP_UNUSED, 32'sh12345678, 5'd0);
    send_op(ple_pkg::OP_DEL_AT, '0, 5'd1);
    send_op(ple_pkg::OP_DEL_AT, '0, 5'd3);
    send_op(ple_pkg::OP_DEL_BACK, '0, 5'd0);
    send_op(ple_pkg::OP_DEL_FRONT, '0, 5'd0);
    send_op(ple_pkg::OP_READ, '0, 5'd0);

    run_random(320);

    send_idle_pct = 59;
    recv_idle_pct = 22;
    run_random(320);

    // No idling, but one long receiver hold-off so the input side backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 64;
    run_random(340);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d result beats: %0d ok, %0d range, %0d empty, %0d full.",
             board.checked, board.noted, board.by_status[ple_pkg::ST_OK],
             board.by_status[ple_pkg::ST_RANGE], board.by_status[ple_pkg::ST_EMPTY],
             board.by_status[ple_pkg::ST_FULL]);
    $display("Mismatches: %0d", board.errors);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
